// File: sv/tspsi_pkg.sv
// ---------------------------------------------------------------------------
// tspsi_pkg
// Types, constants and per-byte parse steps shared by the PSI section
// reassembler modules.
// ---------------------------------------------------------------------------
package tspsi_pkg;

  localparam int PACKET_BYTES = 188;
  localparam int BUFFER_BYTES = 4096;
  localparam int PAYLOAD_MAX  = 184;

  localparam logic [7:0]  SYNC_MARK = 8'h47;
  localparam logic [12:0] FILL_MAX  = 13'h1fff;

  // Parse phase within one packet
  typedef enum logic [6:0] {
    PH_HDR     = 7'b0000001,
    PH_AFLEN   = 7'b0000010,
    PH_SKIPAF  = 7'b0000100,
    PH_PTR     = 7'b0001000,
    PH_SKIPPTR = 7'b0010000,
    PH_BODY    = 7'b0100000,
    PH_IDLE    = 7'b1000000
  } phase_t;

  // Packet mode: header-only look, new section, continuation
  typedef enum logic [2:0] {
    M_PEEK = 3'b001,
    M_NEW  = 3'b010,
    M_CONT = 3'b100
  } mode_t;

  // Packet status codes
  typedef enum logic [3:0] {
    ST_MORE     = 4'd0,
    ST_COMPLETE = 4'd1,
    ST_NOSYNC   = 4'd2,
    ST_PIDMISS  = 4'd3,
    ST_TEI      = 4'd4,
    ST_DUP      = 4'd5,
    ST_NEWPID   = 4'd6,
    ST_DISCONT  = 4'd7,
    ST_DAMAGED  = 4'd8,
    ST_FULL     = 4'd9
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  payload_byte;
    logic [11:0] buffer_offset;
    logic        packet_done;
    logic [3:0]  status;
    logic [11:0] sect_length;
    logic        scrambled;
  } res_t;

  typedef struct packed {
    logic [7:0]  byte_position;
    logic [31:0] header_word;
    logic [8:0]  skip_count;
    logic [11:0] section_len_or_start;
    logic [12:0] held_pid;
    logic [3:0]  held_continuity;
    logic [12:0] fill_length;
    logic [7:0]  packet_payload_count;
    status_t     packet_verdict;
    phase_t      phase;
    mode_t       mode;
    logic [11:0] peek_len;
  } st_t;

  // Enter the payload body; a payload start too early in the packet is damaged
  function automatic st_t start_body(st_t s, logic [7:0] pos);
    logic [8:0] len;
    len = 9'(PACKET_BYTES) - {1'b0, pos} - 9'd1;
    s.phase = PH_BODY;
    s.packet_payload_count = '0;
    s.peek_len = '0;
    if (s.mode != M_PEEK && len > 9'(PAYLOAD_MAX)) begin
      s.phase = PH_IDLE;
      s.packet_verdict = ST_DAMAGED;
    end else if (s.mode == M_NEW) begin
      s.fill_length = '0;
    end
    return s;
  endfunction

  // After the adaptation field: a new section has a pointer field first
  function automatic st_t after_adaptation(st_t s, logic [7:0] pos);
    if (s.mode == M_NEW) begin
      s.phase = PH_PTR;
    end else begin
      s = start_body(s, pos);
    end
    return s;
  endfunction

  // Check the four header bytes and pick the packet mode
  function automatic st_t decode_header(st_t s, logic [12:0] wanted);
    logic        tei;
    logic        pusi;
    logic [12:0] pid;
    logic [1:0]  afc;
    logic [3:0]  cc;
    logic        stop;
    tei  = s.header_word[23];
    pusi = s.header_word[22];
    pid  = s.header_word[20:8];
    afc  = s.header_word[5:4];
    cc   = s.header_word[3:0];
    stop = 1'b0;
    s.phase = PH_IDLE;
    if (s.header_word[31:24] != SYNC_MARK) begin
      s.packet_verdict = ST_NOSYNC;
      stop = 1'b1;
    end else if (pid != wanted) begin
      s.packet_verdict = ST_PIDMISS;
      stop = 1'b1;
    end else begin
      s.mode = M_PEEK;
      if (afc[0]) begin
        if (tei) begin
          s.packet_verdict = ST_TEI;
          stop = 1'b1;
        end else if (pusi && s.section_len_or_start != '0) begin
          s.packet_verdict = ST_COMPLETE;
          stop = 1'b1;
        end else if (pusi) begin
          s.mode = M_NEW;
        end else if (s.section_len_or_start != '0) begin
          if (s.held_pid == pid && s.held_continuity == cc) begin
            s.packet_verdict = ST_DUP;
            stop = 1'b1;
          end else if (s.held_pid != pid) begin
            s.packet_verdict = ST_NEWPID;
            stop = 1'b1;
          end else begin
            // counter advances even when the packet is a discontinuity
            s.held_continuity = s.held_continuity + 4'd1;
            if (s.held_continuity != cc) begin
              s.packet_verdict = ST_DISCONT;
              stop = 1'b1;
            end else begin
              s.mode = M_CONT;
            end
          end
        end else begin
          s.packet_verdict = ST_MORE;
          stop = 1'b1;
        end
      end
      if (!stop) begin
        if (afc[1]) begin
          s.phase = PH_AFLEN;
        end else begin
          s = after_adaptation(s, 8'd3);
        end
      end
    end
    return s;
  endfunction

endpackage

// File: sv/ts_psi_section_reassembler_core.sv
// ---------------------------------------------------------------------------
// ts_psi_section_reassembler_core
// PSI section reassembler for one PID of an MPEG-2 transport stream.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one transport packet byte per
//   item with packet_start marking byte 0 and restart clearing the section
//   state ahead of that byte. Output channel (out_valid/out_ready) gives a
//   result item for each payload byte appended to the section, and one on
//   the last byte of each packet with packet_done and the status fields.
//   Bytes that cause no result are consumed silently.
//   The config channel (cfg_valid/cfg_ready, always ready) writes the
//   wanted PID; write it only while no item is in flight.
// Timing:
//   One item per cycle sustained while out_ready stays high. An accepted
//   byte sits in the input register, is parsed by the per-byte step logic
//   and lands in the result register once that register can take it.
// Reset:
//   Synchronous rst empties both registers, clears all section state and the
//   PID register; the first byte after reset counts as byte 0 of a packet.
// Stall:
//   While out_ready is low a held result blocks the parser; the input
//   register still takes one more item, then in_ready drops.
// ---------------------------------------------------------------------------
module ts_psi_section_reassembler_core
  import tspsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        packet_start,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        byte_valid,
  output logic [7:0]  payload_byte,
  output logic [11:0] buffer_offset,
  output logic        packet_done,
  output logic [3:0]  status,
  output logic [11:0] sect_length,
  output logic        scrambled
);

  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  advance;
  logic  out_free;
  logic  has_result;
  res_t  res;
  res_t  res_q;

  assign cfg_ready = 1'b1;

  assign in_item.data_byte    = data_byte;
  assign in_item.packet_start = packet_start;
  assign in_item.restart      = restart;

  // parser consumes the held item whenever the result register can take it
  assign advance = s1_valid && out_free;

  tspsi_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  tspsi_parser u_parse (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_pid    (cfg_data),
    .fire       (advance),
    .item       (s1_item),
    .has_result (has_result),
    .res        (res)
  );

  tspsi_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_result),
    .din       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (res_q)
  );

  assign byte_valid     = res_q.byte_valid;
  assign payload_byte   = res_q.payload_byte;
  assign buffer_offset  = res_q.buffer_offset;
  assign packet_done    = res_q.packet_done;
  assign status         = res_q.status;
  assign sect_length    = res_q.sect_length;
  assign scrambled      = res_q.scrambled;

  // a full input register behind a stalled result blocks new items
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while both registers are held");

endmodule

// File: sv/tspsi_in_stage.sv
// ---------------------------------------------------------------------------
// tspsi_in_stage
// Input register: holds one accepted byte item until the parser takes it.
// ---------------------------------------------------------------------------
module tspsi_in_stage
  import tspsi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  s1_valid,
  output item_t s1_item
);

  assign in_ready = !s1_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

endmodule

// File: sv/tspsi_parser.sv
// ---------------------------------------------------------------------------
// tspsi_parser
// Per-byte packet parse: header checks, adaptation and pointer skip, section
// fill and end-of-packet status. State advances once per consumed item.
// ---------------------------------------------------------------------------
module tspsi_parser
  import tspsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_pid,
  input  logic        fire,
  input  item_t       item,
  output logic        has_result,
  output res_t        res
);

  logic [12:0] wanted_pid;
  st_t         st;
  st_t         st_next;
  logic [7:0]  pos;
  status_t     fin;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_pid <= '0;
    end else if (cfg_we) begin
      wanted_pid <= cfg_pid;
    end
  end

  // one byte step
  always_comb begin
    st_next = st;
    res     = '0;
    fin     = ST_MORE;

    pos = item.packet_start ? 8'd0 : st.byte_position;
    if (pos >= 8'(PACKET_BYTES)) begin
      pos = 8'd0;
    end

    if (item.restart) begin
      st_next.section_len_or_start = '0;
      st_next.held_pid             = '0;
      st_next.held_continuity      = '0;
      st_next.fill_length          = '0;
    end

    if (pos == 8'd0) begin
      st_next.header_word          = '0;
      st_next.phase                = PH_HDR;
      st_next.mode                 = M_PEEK;
      st_next.packet_verdict       = ST_MORE;
      st_next.skip_count           = '0;
      st_next.packet_payload_count = '0;
      st_next.peek_len             = '0;
    end

    unique case (st_next.phase)
      PH_HDR: begin
        st_next.header_word = {st_next.header_word[23:0], item.data_byte};
        if (pos == 8'd3) begin
          st_next = decode_header(st_next, wanted_pid);
        end
      end
      PH_AFLEN: begin
        if (item.data_byte == 8'd0) begin
          st_next = after_adaptation(st_next, pos);
        end else begin
          st_next.skip_count = {1'b0, item.data_byte};
          st_next.phase      = PH_SKIPAF;
        end
      end
      PH_SKIPAF: begin
        st_next.skip_count = st_next.skip_count - 9'd1;
        if (st_next.skip_count == '0) begin
          st_next = after_adaptation(st_next, pos);
        end
      end
      PH_PTR: begin
        if (item.data_byte == 8'd0) begin
          st_next = start_body(st_next, pos);
        end else begin
          st_next.skip_count = {1'b0, item.data_byte};
          st_next.phase      = PH_SKIPPTR;
        end
      end
      PH_SKIPPTR: begin
        st_next.skip_count = st_next.skip_count - 9'd1;
        if (st_next.skip_count == '0) begin
          st_next = start_body(st_next, pos);
        end
      end
      PH_BODY: begin
        // append while the buffer has room
        if (st_next.mode != M_PEEK &&
            {4'd0, st_next.fill_length} < 17'(BUFFER_BYTES) &&
            st_next.fill_length < FILL_MAX) begin
          res.byte_valid    = 1'b1;
          res.payload_byte  = item.data_byte;
          res.buffer_offset = st_next.fill_length[11:0];
          st_next.fill_length = st_next.fill_length + 13'd1;
        end
        // section length from payload bytes 1 and 2
        if (st_next.packet_payload_count == 8'd1) begin
          st_next.peek_len = {item.data_byte[3:0], 8'd0};
        end else if (st_next.packet_payload_count == 8'd2) begin
          st_next.peek_len = st_next.peek_len | {4'd0, item.data_byte};
        end
        if (st_next.packet_payload_count != 8'hff) begin
          st_next.packet_payload_count = st_next.packet_payload_count + 8'd1;
        end
      end
      PH_IDLE: begin
      end
      default: begin
      end
    endcase

    // end of packet status
    if (pos == 8'(PACKET_BYTES - 1)) begin
      if (st_next.phase == PH_IDLE) begin
        fin = st_next.packet_verdict;
      end else if (st_next.mode == M_PEEK) begin
        fin = (st_next.phase == PH_BODY && st_next.header_word[22] &&
               ({1'b0, st_next.peek_len} + 13'd3 <=
                {5'd0, st_next.packet_payload_count})) ? ST_COMPLETE : ST_MORE;
      end else if (st_next.phase != PH_BODY) begin
        fin = ST_DAMAGED;
      end else if (st_next.mode == M_NEW) begin
        st_next.section_len_or_start = st_next.peek_len;
        st_next.held_pid             = st_next.header_word[20:8];
        st_next.held_continuity      = st_next.header_word[3:0];
        fin = ({1'b0, st_next.peek_len} + 13'd3 <=
               {5'd0, st_next.packet_payload_count}) ? ST_COMPLETE : ST_MORE;
      end else begin
        fin = ({4'd0, st_next.fill_length} + 17'd188 > 17'(BUFFER_BYTES)) ?
              ST_FULL : ST_MORE;
      end
      res.packet_done    = 1'b1;
      res.status         = fin;
      res.sect_length    = st_next.section_len_or_start;
      res.scrambled      = (st_next.header_word[7:6] != 2'd0);
      st_next.byte_position = 8'd0;
    end else begin
      st_next.byte_position = pos + 8'd1;
    end
  end

  assign has_result = res.byte_valid || res.packet_done;

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.byte_position        <= '0;
      st.header_word          <= '0;
      st.skip_count           <= '0;
      st.section_len_or_start <= '0;
      st.held_pid             <= '0;
      st.held_continuity      <= '0;
      st.fill_length          <= '0;
      st.packet_payload_count <= '0;
      st.packet_verdict       <= ST_MORE;
      st.phase                <= PH_HDR;
      st.mode                 <= M_PEEK;
      st.peek_len             <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // appended byte moves the fill pointer one past its offset
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    fire && res.byte_valid |=>
      st.fill_length == 13'($past(res.buffer_offset)) + 13'd1)
    else $error("fill length does not follow appended offset");

  // a packet end rewinds the byte position
  a_pos_wrap: assert property (@(posedge clk) disable iff (rst)
    fire && res.packet_done |=> st.byte_position == 8'd0)
    else $error("byte position not rewound after packet end");

endmodule

// File: sv/tspsi_out_stage.sv
// ---------------------------------------------------------------------------
// tspsi_out_stage
// Result register: holds one result item until the receiver takes it.
// ---------------------------------------------------------------------------
module tspsi_out_stage
  import tspsi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t din,
  output logic free,
  output logic out_valid,
  input  logic out_ready,
  output res_t dout
);

  assign free = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

  // only items that carry a byte or a status are shown
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dout.byte_valid || dout.packet_done))
    else $error("empty result item presented");

endmodule
